// ===== rtl/core/i2c_register_transfer_sequencer_top_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define I2CRTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define I2CRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/i2crts_pkg.sv =====
package i2crts_pkg;

    localparam int INDEX_W     = 16;
    localparam int SIZE_W      = 16;
    localparam int CR2_W       = 26;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    // Request kinds
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_EVENT = 2'd1;
    localparam logic [1:0] REQ_ERROR = 2'd2;
    localparam logic [1:0] REQ_ABORT = 2'd3;

    // Transfer phases
    localparam logic [1:0] PH_REGADDR  = 2'd0;
    localparam logic [1:0] PH_READ     = 2'd1;
    localparam logic [1:0] PH_WRITE    = 2'd2;
    localparam logic [1:0] PH_COMPLETE = 2'd3;

    // Status flag bit positions
    localparam int F_TXIS  = 0;
    localparam int F_TC    = 1;
    localparam int F_TCR   = 2;
    localparam int F_NACKF = 3;
    localparam int F_RXNE  = 4;
    localparam int F_TXE   = 5;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_NACK  = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // CR2 bit positions
    localparam int CR2_RD_WRN_BIT = 10;
    localparam int CR2_START_BIT  = 13;
    localparam int CR2_NBYTES_LSB = 16;
    localparam int CR2_RELOAD_BIT = 24;

    // Interrupt enables
    localparam logic [4:0] IRQ_RX         = 5'h02;
    localparam logic [4:0] IRQ_START_MASK = 5'h1D;

    localparam logic [3:0] ICR_NACK = 4'h1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [9:0]        slave_addr;
        logic [7:0]        reg_addr;
        logic [SIZE_W-1:0] transfer_size;
        logic              is_read;
        logic              send_reg_addr;
        logic [5:0]        isr_flags;
        logic [2:0]        err_flags;
        logic [7:0]        rx_byte;
        logic [7:0]        tx_byte;
    } t_in_item;

    typedef struct packed {
        logic               cr2_write;
        logic [CR2_W-1:0]   ctrl_value;
        logic               stop_request;
        logic               txdr_write;
        logic [7:0]         txdr_byte;
        logic               rx_store;
        logic [INDEX_W-1:0] store_index;
        logic [INDEX_W-1:0] next_index;
        logic [3:0]         icr_clear;
        logic [4:0]         irq_enable;
        logic [1:0]         event_code;
        logic               fault;
    } t_result;

endpackage

// ===== rtl/core/i2crts_engine.sv =====
module i2crts_engine
    import i2crts_pkg::*;
#(
    parameter int CHUNK_MAX = 255
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    output t_result  o_result
);

    localparam logic [7:0] CHUNK = 8'(CHUNK_MAX);

    logic [1:0]         r_phase, n_phase;
    logic               r_read_dir, n_read_dir;
    logic [9:0]         r_target, n_target;
    logic [7:0]         r_reg_byte, n_reg_byte;
    logic [SIZE_W-1:0]  r_total, n_total;
    logic [INDEX_W-1:0] r_index, n_index;
    logic [4:0]         r_mask, n_mask;

    t_result res;
    logic    xfer_end;
    logic [5:0] isr;

    function automatic logic [CR2_W-1:0] cr2_word(input logic [9:0] sadd,
                                                  input logic rd_wrn,
                                                  input logic [7:0] nbytes,
                                                  input logic reload,
                                                  input logic start);
        logic [CR2_W-1:0] w;
        w = '0;
        w[9:0] = sadd;
        w[CR2_RD_WRN_BIT] = rd_wrn;
        w[CR2_START_BIT] = start;
        w[CR2_NBYTES_LSB +: 8] = nbytes;
        w[CR2_RELOAD_BIT] = reload;
        return w;
    endfunction

    // Reload with a full chunk when the rest will not fit (or index ran past)
    function automatic logic [CR2_W-1:0] chunk_cr2(input logic [9:0] sadd,
                                                   input logic rd_wrn,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [SIZE_W-1:0] total,
                                                   input logic start);
        logic [SIZE_W-1:0] rem;
        logic              over;
        rem  = total - idx;
        over = (idx > total) || (rem > {{(SIZE_W-8){1'b0}}, CHUNK});
        return cr2_word(sadd, rd_wrn, over ? CHUNK : rem[7:0], over, start);
    endfunction

    always_comb begin
        n_phase    = r_phase;
        n_read_dir = r_read_dir;
        n_target   = r_target;
        n_reg_byte = r_reg_byte;
        n_total    = r_total;
        n_index    = r_index;
        n_mask     = r_mask;
        res        = '0;
        xfer_end   = 1'b0;
        isr        = i_item.isr_flags;

        case (i_item.req_type)
            REQ_START: begin
                n_read_dir = i_item.is_read;
                n_target   = i_item.slave_addr;
                n_reg_byte = i_item.reg_addr;
                n_total    = i_item.transfer_size;
                n_index    = '0;
                if (i_item.send_reg_addr) begin
                    n_phase = PH_REGADDR;
                end else if (i_item.is_read) begin
                    n_phase = PH_READ;
                end else begin
                    n_phase = PH_WRITE;
                end
                n_mask = IRQ_START_MASK | (i_item.is_read ? IRQ_RX : 5'h00);
                res.cr2_write = 1'b1;
                if (i_item.send_reg_addr) begin
                    // one address byte; a write keeps going with reload
                    res.ctrl_value = cr2_word(i_item.slave_addr, 1'b0, 8'd1,
                                              !i_item.is_read, 1'b1);
                end else begin
                    res.ctrl_value = chunk_cr2(i_item.slave_addr, i_item.is_read,
                                               '0, i_item.transfer_size, 1'b1);
                end
            end
            REQ_EVENT: begin
                case (r_phase)
                    PH_REGADDR: begin
                        if (isr[F_TXIS]) begin
                            res.txdr_write = 1'b1;
                            res.txdr_byte  = r_reg_byte;
                        end
                        if (r_read_dir && isr[F_TC]) begin
                            n_phase        = PH_READ;
                            res.cr2_write  = 1'b1;
                            res.ctrl_value = chunk_cr2(r_target, r_read_dir, r_index,
                                                       r_total, 1'b1);
                        end else if (!r_read_dir && isr[F_TCR]) begin
                            n_phase        = PH_WRITE;
                            res.cr2_write  = 1'b1;
                            res.ctrl_value = chunk_cr2(r_target, r_read_dir, r_index,
                                                       r_total, 1'b0);
                        end
                        if (isr[F_NACKF]) begin
                            res.icr_clear  = ICR_NACK;
                            res.event_code = EV_NACK;
                        end
                    end
                    PH_READ: begin
                        if (isr[F_RXNE]) begin
                            res.rx_store    = 1'b1;
                            res.store_index = r_index;
                            n_index         = r_index + 1'b1;
                        end
                        if (isr[F_TCR]) begin
                            res.cr2_write  = 1'b1;
                            res.ctrl_value = chunk_cr2(r_target, r_read_dir, n_index,
                                                       r_total, 1'b0);
                        end
                        xfer_end = isr[F_TC];
                    end
                    PH_WRITE: begin
                        if (isr[F_TXIS]) begin
                            res.txdr_write = 1'b1;
                            res.txdr_byte  = i_item.tx_byte;
                            n_index        = r_index + 1'b1;
                        end
                        // NACK wins over TCR/TC in the same request
                        if (isr[F_NACKF]) begin
                            res.icr_clear  = ICR_NACK;
                            res.event_code = EV_NACK;
                        end else begin
                            if (isr[F_TCR]) begin
                                res.cr2_write  = 1'b1;
                                res.ctrl_value = chunk_cr2(r_target, r_read_dir, n_index,
                                                           r_total, 1'b0);
                            end
                            xfer_end = isr[F_TC];
                        end
                    end
                    default: begin
                        // idle: an event with TXE set is harmless, one without TXE is a fault
                        res.fault = !isr[F_TXE];
                    end
                endcase
                if (xfer_end) begin
                    n_mask           = '0;
                    res.stop_request = 1'b1;
                    n_phase          = PH_COMPLETE;
                    res.event_code   = EV_DONE;
                end
            end
            REQ_ERROR: begin
                res.icr_clear    = {i_item.err_flags, 1'b0};
                n_mask           = '0;
                res.stop_request = 1'b1;
                n_phase          = PH_COMPLETE;
                res.event_code   = EV_ERROR;
            end
            default: begin
                n_mask           = '0;
                res.stop_request = 1'b1;
            end
        endcase

        res.next_index = n_index;
        res.irq_enable = n_mask;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_COMPLETE;
            r_read_dir <= 1'b0;
            r_target   <= '0;
            r_reg_byte <= '0;
            r_total    <= '0;
            r_index    <= '0;
            r_mask     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_read_dir <= n_read_dir;
            r_target   <= n_target;
            r_reg_byte <= n_reg_byte;
            r_total    <= n_total;
            r_index    <= n_index;
            r_mask     <= n_mask;
        end
    end

endmodule

// ===== rtl/core/i2c_register_transfer_sequencer_top.sv =====
// I2C register transfer sequencer. Takes one request per clock on the slave
// stream while the master side is not stalled, and returns exactly one result
// per request on the master stream, in order. A request lands in an input
// register, is evaluated against the transfer state in one short combinational
// step, and the result is captured in an output register, from which it is
// offered on the master side. The input and output registers
// form a two-entry pipeline: a new request is taken every cycle unless the
// input register holds a request that cannot move on because the output
// register is full and stalled; a stalled master side holds both stages.
// Transfer state (phase, byte index, interrupt mask) advances only when a
// request moves from the input register to the output register.
module i2c_register_transfer_sequencer_top
    import i2crts_pkg::*;
#(
    parameter int CHUNK_MAX = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [9:0] slave_addr, [17:10] reg_addr, [33:18] transfer_size,
    // [34] is_read, [35] send_reg_addr, [41:36] isr_flags, [44:42] err_flags,
    // [52:45] rx_byte, [60:53] tx_byte, [63:61] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] cr2_write, [26:1] ctrl_value, [27] stop_request, [28] txdr_write,
    // [36:29] txdr_byte, [37] rx_store, [53:38] store_index,
    // [69:54] next_index, [73:70] icr_clear, [78:74] irq_enable,
    // [80:79] event_code, [81] fault, [87:82] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic                   r_in_valid;
    t_in_item               r_in_item;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    t_in_item in_item;
    t_result  result;
    logic     advance;
    logic     s_accept;

    assign in_item.req_type      = i_s_axis_tuser;
    assign in_item.slave_addr    = i_s_axis_tdata[9:0];
    assign in_item.reg_addr      = i_s_axis_tdata[17:10];
    assign in_item.transfer_size = i_s_axis_tdata[33:18];
    assign in_item.is_read       = i_s_axis_tdata[34];
    assign in_item.send_reg_addr = i_s_axis_tdata[35];
    assign in_item.isr_flags     = i_s_axis_tdata[41:36];
    assign in_item.err_flags     = i_s_axis_tdata[44:42];
    assign in_item.rx_byte       = i_s_axis_tdata[52:45];
    assign in_item.tx_byte       = i_s_axis_tdata[60:53];

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    i2crts_engine #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out_tdata <= {6'd0,
                            result.fault,
                            result.event_code,
                            result.irq_enable,
                            result.icr_clear,
                            result.next_index,
                            result.store_index,
                            result.rx_store,
                            result.txdr_byte,
                            result.txdr_write,
                            result.stop_request,
                            result.ctrl_value,
                            result.cr2_write};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;

endmodule

// ===== rtl/core/i2crts_checker.sv =====
`include "i2c_register_transfer_sequencer_top_macros.svh"

module i2crts_checker
    import i2crts_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic                   out_vld;
    logic                   out_stall;
    logic [OUT_TDATA_W-1:0] out_data;
    logic                   cr2_wr;
    logic [CR2_W-1:0]       cr2_val;
    logic                   stop_req;
    logic                   tx_wr;
    logic [7:0]             tx_val;
    logic                   rx_st;
    logic [INDEX_W-1:0]     st_idx;
    logic [4:0]             irq_en;
    logic [1:0]             ev_code;
    logic                   flt;
    logic                   ev_end;
    logic                   side_fx;
    logic                   no_data;
    logic                   data_zero;

    assign out_vld   = o_m_axis_tvalid;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_data  = o_m_axis_tdata;
    assign cr2_wr    = o_m_axis_tdata[0];
    assign cr2_val   = o_m_axis_tdata[26:1];
    assign stop_req  = o_m_axis_tdata[27];
    assign tx_wr     = o_m_axis_tdata[28];
    assign tx_val    = o_m_axis_tdata[36:29];
    assign rx_st     = o_m_axis_tdata[37];
    assign st_idx    = o_m_axis_tdata[53:38];
    assign irq_en    = o_m_axis_tdata[78:74];
    assign ev_code   = o_m_axis_tdata[80:79];
    assign flt       = o_m_axis_tdata[81];
    assign ev_end    = (ev_code == EV_DONE) || (ev_code == EV_ERROR);
    assign side_fx   = cr2_wr || stop_req || (ev_code != EV_NONE);
    assign no_data   = !tx_wr && !rx_st;
    assign data_zero = (tx_val == '0) && (st_idx == '0);

    `I2CRTS_ASSERT_NEXT(a_out_hold, out_stall, out_vld && $stable(out_data), "result moved")

    `I2CRTS_ASSERT_NOW(a_cr2_quiet, out_vld && !cr2_wr, cr2_val == '0, "stray cr2 value")

    `I2CRTS_ASSERT_NOW(a_end_masks, out_vld && ev_end, stop_req && irq_en == '0, "end without stop")

    `I2CRTS_ASSERT_NOW(a_fault_inert, out_vld && flt, !side_fx, "fault with side effects")

    `I2CRTS_ASSERT_NOW(a_data_quiet, out_vld && no_data, data_zero, "stale tx byte or index")

endmodule

bind i2c_register_transfer_sequencer_top i2crts_checker u_i2crts_checker (.*);
